>>> hw/rtl/pjq_pkg.sv
// Shared types, codes and field widths of the policy sorted job queue.
`default_nettype none

package pjq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int TAG_W   = 8;
   localparam int CPU_W   = 16;
   localparam int URG_W   = 8;
   localparam int OCC_W   = 5;
   localparam int TOTAL_W = 32;
   localparam int POL_W   = 2;

   localparam int REQ_DATA_W = TAG_W + CPU_W + URG_W;
   localparam int RSP_DATA_W = 2 + TAG_W + CPU_W + URG_W + OCC_W + 1 + 2 * TOTAL_W;

   // Ordering policy codes.
   localparam logic [POL_W-1:0] POL_ARRIVAL  = 2'd0;
   localparam logic [POL_W-1:0] POL_SHORTEST = 2'd1;
   localparam logic [POL_W-1:0] POL_PRIORITY = 2'd2;

   // Request kind codes.
   localparam logic KIND_SUBMIT   = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   typedef struct packed {
      logic load;    // capture the request beat and the per-cell compares
      logic commit;  // update the cells and load the response register
   } pjq_cmd_type;

   typedef struct packed {
      logic out_valid;  // response register holds a beat not yet taken
   } pjq_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/pjq_ctrl.sv
// Controller state machine of the job queue: accept a request, then commit it.
`default_nettype none

module pjq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire                  rsp_tready,
   input  pjq_pkg::pjq_stat_type stat,
   output pjq_pkg::pjq_cmd_type  cmd
);
   import pjq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      can_commit;

   assign req_tready = (state_ff == ST_IDLE);
   // The response register is free when empty or when its beat leaves now.
   assign can_commit = !stat.out_valid || rsp_tready;

   always_comb begin
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (can_commit) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pjq_datapath.sv
// Datapath of the job queue: cell chain of slots, totals and response register.
`default_nettype none

module pjq_datapath #(
   parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_wr_en,
   input  wire  [pjq_pkg::POL_W-1:0]         csr_wr_data,
   input  wire  [pjq_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire  [0:0]                        req_tuser,
   input  pjq_pkg::pjq_cmd_type               cmd,
   output pjq_pkg::pjq_stat_type              stat,
   input  wire                               rsp_tready,
   output logic [pjq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pjq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LG = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Slot cells, shifted as the queue grows or shrinks.
   logic [TAG_W-1:0] tag_ff [QUEUE_DEPTH];
   logic [CPU_W-1:0] cpu_ff [QUEUE_DEPTH];
   logic [URG_W-1:0] urg_ff [QUEUE_DEPTH];
   logic [TAG_W-1:0] tag_in [QUEUE_DEPTH];
   logic [CPU_W-1:0] cpu_in [QUEUE_DEPTH];
   logic [URG_W-1:0] urg_in [QUEUE_DEPTH];
   logic [TAG_W-1:0] up_tag [QUEUE_DEPTH];
   logic [CPU_W-1:0] up_cpu [QUEUE_DEPTH];
   logic [URG_W-1:0] up_urg [QUEUE_DEPTH];
   logic [TAG_W-1:0] dn_tag [QUEUE_DEPTH];
   logic [CPU_W-1:0] dn_cpu [QUEUE_DEPTH];
   logic [URG_W-1:0] dn_urg [QUEUE_DEPTH];

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [TOTAL_W-1:0] cpu_total_ff;
   logic [TOTAL_W-1:0] cpu_total_in;
   logic [TOTAL_W-1:0] jobs_total_ff;
   logic [TOTAL_W-1:0] jobs_total_in;
   logic [POL_W-1:0]   policy_ff;

   // Captured request beat.
   logic               kind_ff;
   logic [TAG_W-1:0]   item_tag_ff;
   logic [CPU_W-1:0]   item_cpu_ff;
   logic [URG_W-1:0]   item_urg_ff;
   logic [QUEUE_DEPTH-1:0] gt_ff;
   logic [QUEUE_DEPTH-1:0] gt_in;

   logic [TAG_W-1:0]   req_tag;
   logic [CPU_W-1:0]   req_cpu;
   logic [URG_W-1:0]   req_urg;

   logic [QUEUE_DEPTH-1:0] place;
   logic [QUEUE_DEPTH-1:0] pre [LG+1];
   logic [QUEUE_DEPTH-1:0] shift_up;

   logic               is_full_now;
   logic               do_submit;
   logic               do_dispatch;
   logic [TOTAL_W:0]   cpu_sum_wide;
   logic [31:0]        count_wide;

   logic               res_acc;
   logic               res_hv;
   logic [TAG_W-1:0]   res_tag;
   logic [CPU_W-1:0]   res_cpu;
   logic [URG_W-1:0]   res_urg;

   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_tag = req_tdata[TAG_W-1:0];
   assign req_cpu = req_tdata[TAG_W+CPU_W-1:TAG_W];
   assign req_urg = req_tdata[REQ_DATA_W-1:TAG_W+CPU_W];

   // Each waiting cell behind the head compares its key with the incoming job at accept time.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt_in[i] = (i != 0) && (count_ff > CW'(i)) &&
                    (((policy_ff == POL_SHORTEST) && (cpu_ff[i] > req_cpu)) ||
                     ((policy_ff == POL_PRIORITY) && (urg_ff[i] > req_urg)));
      end
   end

   // The new job lands in the first cell whose key is greater, else at the tail.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         place[i] = gt_ff[i] || (count_ff == CW'(i));
      end
      pre[0] = place;
      for (int l = 0; l < LG; l++) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i >= (1 << l)) begin
               pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
            end else begin
               pre[l+1][i] = pre[l][i];
            end
         end
      end
      shift_up = {pre[LG][QUEUE_DEPTH-2:0], 1'b0};
   end

   assign is_full_now = (count_ff == DEPTH_C);
   assign do_submit   = cmd.commit && (kind_ff == KIND_SUBMIT) && !is_full_now;
   assign do_dispatch = cmd.commit && (kind_ff == KIND_DISPATCH) && (count_ff != '0);

   always_comb begin
      up_tag[0] = item_tag_ff;
      up_cpu[0] = item_cpu_ff;
      up_urg[0] = item_urg_ff;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         up_tag[i] = tag_ff[i-1];
         up_cpu[i] = cpu_ff[i-1];
         up_urg[i] = urg_ff[i-1];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         dn_tag[i] = tag_ff[i+1];
         dn_cpu[i] = cpu_ff[i+1];
         dn_urg[i] = urg_ff[i+1];
      end
      dn_tag[QUEUE_DEPTH-1] = tag_ff[QUEUE_DEPTH-1];
      dn_cpu[QUEUE_DEPTH-1] = cpu_ff[QUEUE_DEPTH-1];
      dn_urg[QUEUE_DEPTH-1] = urg_ff[QUEUE_DEPTH-1];
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         priority if (do_submit && shift_up[i]) begin
            tag_in[i] = up_tag[i];
            cpu_in[i] = up_cpu[i];
            urg_in[i] = up_urg[i];
         end else if (do_submit && place[i]) begin
            tag_in[i] = item_tag_ff;
            cpu_in[i] = item_cpu_ff;
            urg_in[i] = item_urg_ff;
         end else if (do_dispatch) begin
            tag_in[i] = dn_tag[i];
            cpu_in[i] = dn_cpu[i];
            urg_in[i] = dn_urg[i];
         end else begin
            tag_in[i] = tag_ff[i];
            cpu_in[i] = cpu_ff[i];
            urg_in[i] = urg_ff[i];
         end
      end
   end

   // Counters, saturating totals and the response fields.
   always_comb begin
      count_in      = count_ff;
      cpu_total_in  = cpu_total_ff;
      jobs_total_in = jobs_total_ff;
      cpu_sum_wide  = {1'b0, cpu_total_ff} + (TOTAL_W + 1)'(item_cpu_ff);
      res_acc       = 1'b0;
      res_hv        = 1'b0;
      res_tag       = '0;
      res_cpu       = '0;
      res_urg       = '0;
      if (kind_ff == KIND_SUBMIT) begin
         res_hv = 1'b1;
         if (!is_full_now) begin
            res_acc      = 1'b1;
            count_in     = count_ff + CW'(1);
            cpu_total_in = cpu_sum_wide[TOTAL_W] ? '1 : cpu_sum_wide[TOTAL_W-1:0];
            if (jobs_total_ff != '1) begin
               jobs_total_in = jobs_total_ff + TOTAL_W'(1);
            end
         end
         if (count_ff == '0) begin
            res_tag = item_tag_ff;
            res_cpu = item_cpu_ff;
            res_urg = item_urg_ff;
         end else begin
            res_tag = tag_ff[0];
            res_cpu = cpu_ff[0];
            res_urg = urg_ff[0];
         end
      end else if (count_ff != '0) begin
         res_acc  = 1'b1;
         res_hv   = 1'b1;
         res_tag  = tag_ff[0];
         res_cpu  = cpu_ff[0];
         res_urg  = urg_ff[0];
         count_in = count_ff - CW'(1);
      end
      count_wide = 32'(count_in);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tag_ff[i] <= tag_in[i];
         cpu_ff[i] <= cpu_in[i];
         urg_ff[i] <= urg_in[i];
      end
      if (cmd.load) begin
         kind_ff     <= req_tuser[0];
         item_tag_ff <= req_tag;
         item_cpu_ff <= req_cpu;
         item_urg_ff <= req_urg;
         gt_ff       <= gt_in;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {jobs_total_in, cpu_total_in, (count_in == DEPTH_C),
                         count_wide[OCC_W-1:0], res_urg, res_cpu, res_tag,
                         res_hv, res_acc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cpu_total_ff  <= '0;
         jobs_total_ff <= '0;
         policy_ff     <= POL_ARRIVAL;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            count_ff      <= count_in;
            cpu_total_ff  <= cpu_total_in;
            jobs_total_ff <= jobs_total_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_valid = out_valid_ff;
   assign rsp_tdata      = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/policy_sorted_job_queue_unit.sv
// Top level of the policy sorted job queue: controller plus cell-chain datapath.
//
//  Port group  Dir  Payload (low bit first)
//  req_*       in   tdata: job_tag[7:0] cpu_need[23:8] urgency[31:24]; tuser: kind
//  rsp_*       out  tdata: accepted, head_valid, head_tag, head_cpu, head_urgency,
//                   occupancy, is_full, cpu_sum, submit_count
//  csr_*       in   csr_wr_data: policy
//
// A request is accepted in ST_IDLE, where the accept edge captures the beat and every
// cell's key compare; its commit in ST_BUSY shifts the cell chain and loads the response.
// A response waiting on rsp_tready does not block the next accept; the commit of
// that next request waits until the response register is free.
// Reset (synchronous) empties the queue and clears the totals and the policy.
`default_nettype none

module policy_sorted_job_queue_unit #(
   parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_wr_en,
   input  wire  [pjq_pkg::POL_W-1:0]      csr_wr_data,   // policy
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [pjq_pkg::REQ_DATA_W-1:0] req_tdata,     // job_tag, cpu_need, urgency
   input  wire  [0:0]                     req_tuser,     // kind
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [pjq_pkg::RSP_DATA_W-1:0] rsp_tdata      // accepted .. submit_count
);
   import pjq_pkg::*;

   pjq_cmd_type  cmd;
   pjq_stat_type stat;

   pjq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pjq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   assign rsp_tvalid = stat.out_valid;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the policy sorted job queue: directed, pressure and random beats.
`timescale 1ns / 1ps

module tb_top;
   import pjq_pkg::*;

   localparam int QDEPTH     = QUEUE_DEPTH_DEF;
   localparam int STALL_MAX  = 2000;
   localparam int SETTLE_CYC = 10;

   // The one policy code without a rule of its own; it orders like arrival.
   localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;

   typedef struct packed {
      logic [URG_W-1:0] urgency;
      logic [CPU_W-1:0] cpu;
      logic [TAG_W-1:0] tag;
   } job_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] submit_count;
      logic [TOTAL_W-1:0] cpu_sum;
      logic               is_full;
      logic [OCC_W-1:0]   occupancy;
      logic [URG_W-1:0]   head_urgency;
      logic [CPU_W-1:0]   head_cpu;
      logic [TAG_W-1:0]   head_tag;
      logic               head_valid;
      logic               accepted;
   } head_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [POL_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow state of the queue, advanced at each accepted request beat.
   job_type            job_store [QDEPTH];
   int unsigned        job_count = 0;
   logic [TOTAL_W-1:0] cpu_total = '0;
   logic [TOTAL_W-1:0] jobs_total = '0;
   logic [POL_W-1:0]   policy_now = POL_ARRIVAL;

   head_report_type pending_reports[$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           idle_on = 1'b1;
   int           holdoff_req = 0;
   int           rx_hold = 0;
   int           rx_gap = 0;

   policy_sorted_job_queue_unit #(.QUEUE_DEPTH(QDEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic logic [CPU_W-1:0] order_key(job_type job);
      if (policy_now == POL_SHORTEST) return job.cpu;
      if (policy_now == POL_PRIORITY) return {{(CPU_W-URG_W){1'b0}}, job.urgency};
      return '0;
   endfunction

   function automatic head_report_type predict_head_report(logic kind, job_type job);
      head_report_type r;
      int unsigned  pos;
      bit           found;
      logic [TOTAL_W:0] sum;
      r = '0;
      if (kind == KIND_SUBMIT) begin
         if (job_count < QDEPTH) begin
            pos = job_count;
            found = 1'b0;
            // A new job goes behind every waiting job whose key is not greater than its own.
            if (job_count > 0 && (policy_now == POL_SHORTEST || policy_now == POL_PRIORITY)) begin
               for (int p = 1; p < job_count; p++) begin
                  if (!found && order_key(job_store[p]) > order_key(job)) begin
                     pos = p;
                     found = 1'b1;
                  end
               end
            end
            for (int i = job_count; i > pos; i--) job_store[i] = job_store[i-1];
            job_store[pos] = job;
            job_count++;
            sum = {1'b0, cpu_total} + job.cpu;
            cpu_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (jobs_total != '1) jobs_total++;
            r.accepted = 1'b1;
         end
         if (job_count > 0) begin
            r.head_valid   = 1'b1;
            r.head_tag     = job_store[0].tag;
            r.head_cpu     = job_store[0].cpu;
            r.head_urgency = job_store[0].urgency;
         end
      end else if (job_count > 0) begin
         r.accepted     = 1'b1;
         r.head_valid   = 1'b1;
         r.head_tag     = job_store[0].tag;
         r.head_cpu     = job_store[0].cpu;
         r.head_urgency = job_store[0].urgency;
         for (int i = 1; i < job_count; i++) job_store[i-1] = job_store[i];
         job_count--;
      end
      r.occupancy    = OCC_W'(job_count);
      r.is_full      = (job_count == QDEPTH);
      r.cpu_sum      = cpu_total;
      r.submit_count = jobs_total;
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result checker: every response beat is matched against the oldest prediction.
   always @(posedge clock) begin
      head_report_type want;
      head_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_reports.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("head_valid", want.head_valid, got.head_valid);
            check_field("head_tag", want.head_tag, got.head_tag);
            check_field("head_cpu", want.head_cpu, got.head_cpu);
            check_field("head_urgency", want.head_urgency, got.head_urgency);
            check_field("occupancy", want.occupancy, got.occupancy);
            check_field("is_full", want.is_full, got.is_full);
            check_field("cpu_sum", want.cpu_sum, got.cpu_sum);
            check_field("submit_count", want.submit_count, got.submit_count);
         end
      end
   end

   // Watchdog on cycles without any beat on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_MAX) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: a requested long hold-off first, then random stall bursts.
   always @(negedge clock) begin
      if (holdoff_req != 0) begin
         rx_hold = holdoff_req;
         holdoff_req = 0;
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rx_gap = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Returns at the rising edge where the beat was taken.
   task automatic send_job(logic kind, job_type job);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= job;
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_head_report(kind, job));
   endtask

   task automatic submit(logic [7:0] tag, logic [15:0] cpu, logic [7:0] urgency);
      send_job(KIND_SUBMIT, '{urgency: urgency, cpu: cpu, tag: tag});
   endtask

   task automatic dispatch();
      send_job(KIND_DISPATCH, job_type'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_policy(logic [POL_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      policy_now = value;
   endtask

   function automatic job_type random_job();
      job_type j;
      j.tag = TAG_W'($urandom_range(0, 255));
      // Narrow key ranges make ties common; wide ones cover every bit.
      case ($urandom_range(0, 2))
         0: j.cpu = CPU_W'($urandom_range(0, 3));
         1: j.cpu = CPU_W'($urandom_range(0, 65535));
         default: j.cpu = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
      case ($urandom_range(0, 2))
         0: j.urgency = URG_W'($urandom_range(0, 3));
         1: j.urgency = URG_W'($urandom_range(0, 255));
         default: j.urgency = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      return j;
   endfunction

   task automatic test_empty_and_extremes();
      write_policy(POL_ARRIVAL);
      dispatch();
      submit(8'hFF, 16'hFFFF, 8'hFF);
      submit(8'h00, 16'h0000, 8'h00);
      submit(8'hA5, 16'h5A5A, 8'h5A);
      dispatch();
      dispatch();
      dispatch();
   endtask

   task automatic test_shortest_with_ties();
      write_policy(POL_SHORTEST);
      submit(8'h10, 16'd500, 8'd9);
      submit(8'h11, 16'd300, 8'd9);
      submit(8'h12, 16'd300, 8'd9);
      submit(8'h13, 16'd0, 8'd9);
      submit(8'h14, 16'hFFFF, 8'd9);
      submit(8'h15, 16'd300, 8'd9);
   endtask

   // The waiting jobs keep their order when the policy changes under them.
   task automatic test_policy_switch_while_waiting();
      write_policy(POL_PRIORITY);
      submit(8'h20, 16'd7, 8'd0);
      submit(8'h21, 16'd7, 8'hFF);
      write_policy(POL_UNUSED);
      submit(8'h22, 16'd1, 8'd0);
   endtask

   // Receiver holds off while requests keep coming, so the block stalls its input.
   task automatic test_full_queue_backpressure();
      write_policy(POL_PRIORITY);
      holdoff_req = 150;
      for (int i = 0; i < QDEPTH + 3; i++) submit(8'($urandom), 16'($urandom), 8'(i % 4));
      for (int i = 0; i < QDEPTH + 2; i++) dispatch();
      wait_drained();
   endtask

   task automatic test_random_mix(logic [POL_W-1:0] pol, int items, int submit_pct);
      logic kind;
      write_policy(pol);
      for (int i = 0; i < items; i++) begin
         kind = ($urandom_range(0, 99) < submit_pct) ? KIND_SUBMIT : KIND_DISPATCH;
         send_job(kind, random_job());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_shortest_with_ties();
      test_policy_switch_while_waiting();
      test_full_queue_backpressure();

      test_random_mix(POL_ARRIVAL, 220, 55);
      test_random_mix(POL_SHORTEST, 220, 70);
      test_random_mix(POL_PRIORITY, 220, 60);
      idle_on = 1'b0;
      test_random_mix(POL_UNUSED, 200, 50);
      idle_on = 1'b1;
      test_random_mix(POL_SHORTEST, 220, 40);
      test_random_mix(POL_PRIORITY, 220, 75);
      test_random_mix(POL_ARRIVAL, 200, 50);
      test_random_mix(POL_PRIORITY, 200, 45);
      idle_on = 1'b0;
      test_random_mix(POL_SHORTEST, 160, 60);

      wait_drained();
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
